// ===== hdl/cpiosq_pkg.sv =====
// shared types, constants and character tables for the cpio newc id squash filter
package cpiosq_pkg;

  // section codes
  localparam logic [2:0] SEC_HDR  = 3'd0;
  localparam logic [2:0] SEC_NAME = 3'd1;
  localparam logic [2:0] SEC_DATA = 3'd2;
  localparam logic [2:0] SEC_COPY = 3'd3;
  localparam logic [2:0] SEC_HALT = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_BAD_HEX   = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  // header layout, byte offsets within the 110-byte header
  localparam logic [6:0] HDR_LAST    = 7'd109;
  localparam logic [6:0] MAGIC_LEN   = 7'd6;
  localparam logic [6:0] UID_FIRST   = 7'd22;
  localparam logic [6:0] GID_LAST    = 7'd37;
  localparam logic [6:0] FSIZE_FIRST = 7'd54;
  localparam logic [6:0] FSIZE_LAST  = 7'd61;
  localparam logic [6:0] NSIZE_FIRST = 7'd94;
  localparam logic [6:0] NSIZE_LAST  = 7'd101;
  localparam logic [6:0] TRL_LEN     = 7'd11;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  // one result as it leaves the step logic
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] section;
    logic       out_valid;
    logic [7:0] out_byte;
  } res_t;

  // expected magic character at a header offset
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd1:    c = 8'h37;
      3'd3:    c = 8'h37;
      3'd5:    c = 8'h31;
      default: c = 8'h30;
    endcase
    return c;
  endfunction

  // expected trailer name character, NUL included
  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4c;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      4'd7:    c = 8'h21;
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // ascii hex digit decode: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // length extended so that offset plus length lands on a 4-byte boundary
  function automatic logic [32:0] pad_len(input logic [1:0] off, input logic [31:0] n);
    logic [1:0] fill;
    fill = 2'd0 - (off + n[1:0]);
    return {1'b0, n} + {31'd0, fill};
  endfunction

endpackage

// ===== hdl/cpio_newc_id_squash_filter.sv =====
// Byte-stream filter for cpio newc archives: checks each header's magic, forces the
// uid and gid digits to ASCII zero, sizes the name and data from the header's hex
// fields and passes everything through, then copies bytes unchanged after the trailer
// entry. Every input byte request yields exactly one result request. One byte is taken
// per clock while out_tready stays high. An accepted byte is held in the input register
// and goes through the step logic into the output register once that register is free
// or draining, and its result is offered from there. While a
// result waits on out_tready the input register still takes one more byte, then
// in_tready stays low until the output drains. After a bad magic, bad hex digit or
// early end of stream, results carry out_valid low, section 4 and the stored status.
module cpio_newc_id_squash_filter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // stream_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [5:0] out_tuser   // [0] out_valid, [3:1] section, [5:4] status
);
  import cpiosq_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_end;
  logic       adv;
  res_t       step_res;
  logic       out_valid_r;
  logic       out_valid_nxt;
  res_t       res_r;

  // held request moves when the output register is free or draining
  assign adv = hold_valid && (!out_valid_r || out_tready);

  cpiosq_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .adv        (adv),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .hold_end   (hold_end)
  );

  cpiosq_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (adv),
    .data_byte  (hold_byte),
    .stream_end (hold_end),
    .res        (step_res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.out_byte;
  assign out_tuser  = {res_r.status, res_r.section, res_r.out_valid};

  // a suppressed byte only ever comes with the halted section
  a_suppress_halted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tuser[3:1] == SEC_HALT)
    else $error("suppressed byte outside halted section");

  // any error status means the walk has halted
  a_err_halted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[5:4] != ST_OK |-> out_tuser[3:1] == SEC_HALT)
    else $error("error status without halt");

  // an accepted byte is held in the input register on the next cycle
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> hold_valid)
    else $error("accepted byte lost from input register");

  // a moved byte always lands in the output register
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid)
    else $error("step result not presented");

endmodule

// ===== hdl/cpiosq_in_reg.sv =====
// input register stage holding one archive byte request
module cpiosq_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       adv,
  output logic       hold_valid,
  output logic [7:0] hold_byte,
  output logic       hold_end
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       end_r;
  logic       take;

  // free when empty or when the held request moves on this cycle
  assign in_tready = !valid_r || adv;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_tdata;
      end_r  <= in_tlast;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;
  assign hold_end   = end_r;

endmodule

// ===== hdl/cpiosq_core.sv =====
// archive walk state and the combinational step logic for one byte
module cpiosq_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  output cpiosq_pkg::res_t  res
);
  import cpiosq_pkg::*;

  logic [2:0]  sec_r,       sec_nxt;
  logic [6:0]  idx_r,       idx_nxt;
  logic [31:0] name_len_r,  name_len_nxt;
  logic [31:0] file_len_r,  file_len_nxt;
  logic [32:0] rem_r,       rem_nxt;
  logic [1:0]  off_r,       off_nxt;
  logic        magic_ok_r,  magic_ok_nxt;
  logic        hex_ok_r,    hex_ok_nxt;
  logic        trl_r,       trl_nxt;
  logic [1:0]  err_r,       err_nxt;

  logic [1:0]  off_inc;
  logic [32:0] pad_name;
  logic [32:0] pad_file;
  logic [32:0] rem_dec;
  logic [4:0]  hex;
  logic [3:0]  digit;

  assign off_inc  = off_r + 2'd1;
  assign pad_name = pad_len(off_inc, name_len_r);
  assign pad_file = pad_len(off_inc, file_len_r);
  assign rem_dec  = (rem_r != 33'd0) ? rem_r - 33'd1 : rem_r;
  assign hex      = hex_digit(data_byte);
  assign digit    = hex[4] ? hex[3:0] : 4'd0;

  // one step of the header / name / data walk
  always_comb begin
    sec_nxt      = sec_r;
    idx_nxt      = idx_r;
    name_len_nxt = name_len_r;
    file_len_nxt = file_len_r;
    rem_nxt      = rem_r;
    off_nxt      = off_r;
    magic_ok_nxt = magic_ok_r;
    hex_ok_nxt   = hex_ok_r;
    trl_nxt      = trl_r;
    err_nxt      = err_r;
    res.out_byte  = data_byte;
    res.out_valid = 1'b1;

    case (sec_r)
      SEC_HALT: begin
        res.out_byte  = 8'd0;
        res.out_valid = 1'b0;
      end
      SEC_HDR: begin
        off_nxt = off_inc;
        idx_nxt = idx_r + 7'd1;
        if (idx_r < MAGIC_LEN && data_byte != magic_char(idx_r[2:0])) begin
          magic_ok_nxt = 1'b0;
        end
        // uid and gid digits squashed to zero
        if (idx_r >= UID_FIRST && idx_r <= GID_LAST) begin
          res.out_byte = ASCII_ZERO;
        end
        // filesize and namesize hex accumulation
        if (idx_r >= FSIZE_FIRST && idx_r <= FSIZE_LAST) begin
          hex_ok_nxt   = hex_ok_r & hex[4];
          file_len_nxt = {file_len_r[27:0], digit};
        end
        if (idx_r >= NSIZE_FIRST && idx_r <= NSIZE_LAST) begin
          hex_ok_nxt   = hex_ok_r & hex[4];
          name_len_nxt = {name_len_r[27:0], digit};
        end
        // header end: check, then open the name, the data or the next header
        if (idx_r == HDR_LAST) begin
          if (!magic_ok_nxt || !hex_ok_nxt) begin
            err_nxt       = !magic_ok_nxt ? ST_BAD_MAGIC : ST_BAD_HEX;
            sec_nxt       = SEC_HALT;
            res.out_byte  = 8'd0;
            res.out_valid = 1'b0;
          end else begin
            idx_nxt = 7'd0;
            trl_nxt = 1'b1;
            if (pad_name != 33'd0) begin
              rem_nxt = pad_name;
              sec_nxt = SEC_NAME;
            end else if (pad_file != 33'd0) begin
              rem_nxt = pad_file;
              sec_nxt = SEC_DATA;
            end else begin
              rem_nxt      = 33'd0;
              sec_nxt      = SEC_HDR;
              name_len_nxt = 32'd0;
              file_len_nxt = 32'd0;
              magic_ok_nxt = 1'b1;
              hex_ok_nxt   = 1'b1;
            end
          end
        end
      end
      SEC_NAME: begin
        off_nxt = off_inc;
        rem_nxt = rem_dec;
        if (idx_r < TRL_LEN) begin
          if (data_byte != trailer_char(idx_r[3:0])) begin
            trl_nxt = 1'b0;
          end
          idx_nxt = idx_r + 7'd1;
        end
        // name end: trailer or data or next header
        if (rem_dec == 33'd0) begin
          if (trl_nxt && idx_nxt >= TRL_LEN) begin
            sec_nxt = SEC_COPY;
          end else begin
            rem_nxt = pad_file;
            if (pad_file != 33'd0) begin
              sec_nxt = SEC_DATA;
            end else begin
              sec_nxt      = SEC_HDR;
              idx_nxt      = 7'd0;
              name_len_nxt = 32'd0;
              file_len_nxt = 32'd0;
              magic_ok_nxt = 1'b1;
              hex_ok_nxt   = 1'b1;
            end
          end
        end
      end
      SEC_DATA: begin
        off_nxt = off_inc;
        rem_nxt = rem_dec;
        if (rem_dec == 33'd0) begin
          sec_nxt      = SEC_HDR;
          idx_nxt      = 7'd0;
          name_len_nxt = 32'd0;
          file_len_nxt = 32'd0;
          magic_ok_nxt = 1'b1;
          hex_ok_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // end of input before the trailer
    if (stream_end && sec_nxt != SEC_COPY && sec_nxt != SEC_HALT) begin
      err_nxt = ST_TRUNC;
      sec_nxt = SEC_HALT;
    end

    res.section = sec_nxt;
    res.status  = err_nxt;
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r      <= SEC_HDR;
      idx_r      <= 7'd0;
      name_len_r <= 32'd0;
      file_len_r <= 32'd0;
      rem_r      <= 33'd0;
      off_r      <= 2'd0;
      magic_ok_r <= 1'b1;
      hex_ok_r   <= 1'b1;
      trl_r      <= 1'b1;
      err_r      <= ST_OK;
    end else if (step_en) begin
      sec_r      <= sec_nxt;
      idx_r      <= idx_nxt;
      name_len_r <= name_len_nxt;
      file_len_r <= file_len_nxt;
      rem_r      <= rem_nxt;
      off_r      <= off_nxt;
      magic_ok_r <= magic_ok_nxt;
      hex_ok_r   <= hex_ok_nxt;
      trl_r      <= trl_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

// ===== dv/tb_cpio_newc_id_squash_filter.sv =====
// testbench for the cpio newc id squash filter: archive generator, predictor and checker
`timescale 1ns / 1ps

module tb_cpio_newc_id_squash_filter;
  import cpiosq_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_LEN      = 140;
  localparam int HOLD_AT        = 60;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  // header defects
  localparam int FLAW_NONE  = 0;
  localparam int FLAW_MAGIC = 1;
  localparam int FLAW_HEX   = 2;
  localparam int FLAW_BOTH  = 3;

  // header filler styles
  localparam int STYLE_RANDOM = 0;
  localparam int STYLE_LOW    = 1;
  localparam int STYLE_HIGH   = 2;

  // name contents
  localparam int NAME_RANDOM  = 0;
  localparam int NAME_TRAILER = 1;
  localparam int NAME_NEAR    = 2;

  // how the archive ends
  localparam int END_TRAILER = 0;
  localparam int END_MAGIC   = 1;
  localparam int END_HEX     = 2;
  localparam int END_TRUNC   = 3;

  localparam logic [47:0] MAGIC_TXT    = "070701";
  localparam logic [87:0] TRAILER_TXT  = {"TRAILER!!!", 8'h00};
  // characters just outside the hex digit ranges
  localparam logic [47:0] NON_HEX_EDGE = {8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67};

  typedef struct packed {
    logic       last;
    logic [7:0] b;
  } arc_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [5:0] out_tuser;

  arc_byte_t archive_q[$];
  res_t      squashed_q[$];

  int bytes_sent = 0;
  int results_seen = 0;
  int fail_cnt = 0;
  int idle_cycles = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;

  // predictor state
  logic [2:0]  sec;
  logic [6:0]  hidx;
  logic [31:0] nsz;
  logic [31:0] fsz;
  logic [32:0] remain;
  logic [1:0]  off;
  bit          mgood;
  bit          hgood;
  bit          tmatch;
  logic [1:0]  err;

  cpio_newc_id_squash_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // ascii hex digit value, -1 when not a digit
  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return (upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
  endfunction

  // length grown so that it ends on a 4-byte boundary of the stream
  function automatic logic [32:0] word_pad(input logic [31:0] n);
    logic [1:0] fill;
    fill = 2'd0 - (off + n[1:0]);
    return {1'b0, n} + {31'd0, fill};
  endfunction

  // per-phase idle percentage for one side
  function automatic int idle_pct(input bit rx_side);
    case ((bytes_sent / PHASE_LEN) % 4)
      1:       return rx_side ? 0 : 54;
      2:       return rx_side ? 54 : 0;
      3:       return 33;
      default: return 0;
    endcase
  endfunction

  task automatic begin_header();
    sec = SEC_HDR;
    hidx = '0;
    nsz = '0;
    fsz = '0;
    mgood = 1'b1;
    hgood = 1'b1;
  endtask

  task automatic close_name();
    if (tmatch && hidx >= TRL_LEN) begin
      sec = SEC_COPY;
    end else begin
      remain = word_pad(fsz);
      if (remain == 0) begin_header();
      else sec = SEC_DATA;
    end
  endtask

  // predict the result of one archive byte and queue it
  task automatic squash_byte(input logic [7:0] b, input logic last);
    res_t r;
    int   dv;
    r.out_byte = b;
    r.out_valid = 1'b1;
    if (sec == SEC_HALT) begin
      r.out_byte = 8'h00;
      r.out_valid = 1'b0;
    end else begin
      case (sec)
        SEC_HDR: begin
          if (hidx < MAGIC_LEN && b != MAGIC_TXT[8*(5-hidx) +: 8]) mgood = 1'b0;
          if (hidx >= UID_FIRST && hidx <= GID_LAST) r.out_byte = ASCII_ZERO;
          if ((hidx >= FSIZE_FIRST && hidx <= FSIZE_LAST) ||
              (hidx >= NSIZE_FIRST && hidx <= NSIZE_LAST)) begin
            dv = hex_val(b);
            if (dv < 0) begin
              hgood = 1'b0;
              dv = 0;
            end
            if (hidx <= FSIZE_LAST) fsz = {fsz[27:0], 4'(dv)};
            else nsz = {nsz[27:0], 4'(dv)};
          end
          off = off + 2'd1;
          if (hidx == HDR_LAST) begin
            if (!mgood) err = ST_BAD_MAGIC;
            else if (!hgood) err = ST_BAD_HEX;
            if (err != ST_OK) begin
              // defective header: its last byte is dropped
              sec = SEC_HALT;
              r.out_valid = 1'b0;
              r.out_byte = 8'h00;
            end else begin
              remain = word_pad(nsz);
              hidx = '0;
              tmatch = 1'b1;
              if (remain == 0) close_name();
              else sec = SEC_NAME;
            end
          end else begin
            hidx = hidx + 7'd1;
          end
        end
        SEC_NAME: begin
          if (hidx < TRL_LEN) begin
            if (b != TRAILER_TXT[8*(10-hidx) +: 8]) tmatch = 1'b0;
            hidx = hidx + 7'd1;
          end
          off = off + 2'd1;
          if (remain != 0) remain = remain - 33'd1;
          if (remain == 0) close_name();
        end
        SEC_DATA: begin
          off = off + 2'd1;
          if (remain != 0) remain = remain - 33'd1;
          if (remain == 0) begin_header();
        end
        default: ;
      endcase
      // end of input anywhere but in the trailing copy
      if (last && sec != SEC_COPY && sec != SEC_HALT) begin
        err = ST_TRUNC;
        sec = SEC_HALT;
      end
    end
    r.section = sec;
    r.status = err;
    squashed_q.push_back(r);
  endtask

  task automatic put_byte(input logic [7:0] b);
    arc_byte_t a;
    a.b = b;
    a.last = 1'b0;
    archive_q.push_back(a);
  endtask

  // one 110-byte header, optionally with a defect
  task automatic put_header(input logic [31:0] name_sz, input logic [31:0] file_sz,
                            input int flaw, input int style);
    logic [7:0] b;
    int         bad_magic_at;
    int         bad_hex_at;
    bit         up;
    bad_magic_at = (flaw == FLAW_MAGIC || flaw == FLAW_BOTH) ? $urandom_range(0, 5) : -1;
    bad_hex_at = -1;
    if (flaw == FLAW_HEX || flaw == FLAW_BOTH) begin
      bad_hex_at = $urandom_range(0, 1) ? $urandom_range(FSIZE_FIRST, FSIZE_LAST)
                                        : $urandom_range(NSIZE_FIRST, NSIZE_LAST);
    end
    for (int i = 0; i <= HDR_LAST; i++) begin
      up = (style == STYLE_LOW) ? 1'b1 : (style == STYLE_HIGH) ? 1'b0 : 1'($urandom_range(0, 1));
      if (i < MAGIC_LEN) begin
        b = MAGIC_TXT[8*(5-i) +: 8];
      end else if (i >= FSIZE_FIRST && i <= FSIZE_LAST) begin
        b = hex_char(file_sz[4*(FSIZE_LAST-i) +: 4], up);
      end else if (i >= NSIZE_FIRST && i <= NSIZE_LAST) begin
        b = hex_char(name_sz[4*(NSIZE_LAST-i) +: 4], up);
      end else if (i >= UID_FIRST && i <= GID_LAST) begin
        b = (style == STYLE_LOW) ? 8'hff : (style == STYLE_HIGH) ? 8'h00 : 8'($urandom_range(0, 255));
      end else begin
        b = (style == STYLE_LOW) ? 8'h00 : (style == STYLE_HIGH) ? 8'hff : 8'($urandom_range(0, 255));
      end
      if (i == bad_magic_at) b = b ^ 8'($urandom_range(1, 255));
      if (i == bad_hex_at) begin
        if ($urandom_range(0, 1)) begin
          b = NON_HEX_EDGE[8*$urandom_range(0, 5) +: 8];
        end else begin
          b = 8'($urandom_range(0, 255));
          while (hex_val(b) >= 0) b = 8'($urandom_range(0, 255));
        end
      end
      put_byte(b);
    end
  endtask

  // name bytes followed by padding to a word boundary
  task automatic put_name(input int name_sz, input int kind, input bit zero_pad);
    logic [7:0] b;
    int         flip_at;
    flip_at = (kind == NAME_NEAR) ? $urandom_range(0, 10) : -1;
    for (int i = 0; i < name_sz; i++) begin
      if (kind != NAME_RANDOM && i < TRL_LEN) b = TRAILER_TXT[8*(10-i) +: 8];
      else b = 8'($urandom_range(0, 255));
      if (i == flip_at) b = b ^ 8'($urandom_range(1, 255));
      put_byte(b);
    end
    while (archive_q.size() % 4 != 0) put_byte(zero_pad ? 8'h00 : 8'($urandom_range(0, 255)));
  endtask

  task automatic put_data(input int file_sz);
    repeat (file_sz) put_byte(8'($urandom_range(0, 255)));
    while (archive_q.size() % 4 != 0) put_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
  endtask

  task automatic flag_mismatch(input string what, input int expv, input int actv);
    if (fail_cnt < MAX_REPORTS) begin
      $display("result %0d: %s expected %0h, got %0h", results_seen, what, expv, actv);
    end
    fail_cnt++;
  endtask

  // byte driver: takes requests from the archive queue
  always @(posedge clk) begin : drive
    arc_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        squash_byte(in_tdata, in_tlast);
        bytes_sent <= bytes_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (archive_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          nxt = archive_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.b;
          in_tlast <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (rst_n && !hold_done && bytes_sent == HOLD_AT) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (squashed_q.size() == 0) begin
          flag_mismatch("unexpected request, out_tdata", 0, out_tdata);
        end else begin
          want = squashed_q.pop_front();
          if (out_tdata !== want.out_byte) flag_mismatch("out_byte", want.out_byte, out_tdata);
          if (out_tuser[0] !== want.out_valid) flag_mismatch("out_valid", want.out_valid, out_tuser[0]);
          if (out_tuser[3:1] !== want.section) flag_mismatch("section", want.section, out_tuser[3:1]);
          if (out_tuser[5:4] !== want.status) flag_mismatch("status", want.status, out_tuser[5:4]);
        end
        results_seen <= results_seen + 1;
      end
      out_tready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_cpio_newc_id_squash_filter: FAIL");
      $finish;
    end
  end

  // archive generation, reset and end of run
  initial begin
    int        ending;
    int        first_tail;
    int        name_sz;
    int        file_sz;
    int        kind;
    arc_byte_t a;
    int        idx;

    begin_header();
    remain = '0;
    off = '0;
    tmatch = 1'b1;
    err = ST_OK;

    // directed: zero sizes with extreme filler, then a short trailer prefix
    put_header(32'd0, 32'd0, FLAW_NONE, STYLE_LOW);
    put_name(0, NAME_RANDOM, 1'b1);
    put_header(32'd6, 32'd1, FLAW_NONE, STYLE_HIGH);
    put_name(6, NAME_TRAILER, 1'b1);
    put_data(1);

    // random well-formed entries
    while (archive_q.size() < 300) begin
      kind = ($urandom_range(0, 3) == 0) ? NAME_NEAR : NAME_RANDOM;
      name_sz = (kind == NAME_NEAR) ? $urandom_range(11, 16) : $urandom_range(1, 20);
      file_sz = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      put_header(name_sz, file_sz, FLAW_NONE, STYLE_RANDOM);
      put_name(name_sz, kind, 1'($urandom_range(0, 1)));
      put_data(file_sz);
    end

    // closing: half the time a proper trailer, else one kind of failure
    case ($urandom_range(0, 5))
      0, 1, 2: ending = END_TRAILER;
      3:       ending = END_MAGIC;
      4:       ending = END_HEX;
      default: ending = END_TRUNC;
    endcase
    first_tail = archive_q.size();
    case (ending)
      END_TRAILER: begin
        name_sz = $urandom_range(11, 14);
        put_header(name_sz, $urandom, FLAW_NONE, STYLE_RANDOM);
        put_name(name_sz, NAME_TRAILER, 1'b1);
        first_tail = archive_q.size();
        repeat (40) put_byte(8'($urandom_range(0, 255)));
      end
      END_MAGIC, END_HEX: begin
        put_header($urandom_range(1, 20), $urandom_range(0, 40),
                   (ending == END_HEX) ? FLAW_HEX : ($urandom_range(0, 1) ? FLAW_MAGIC : FLAW_BOTH),
                   STYLE_RANDOM);
        first_tail = archive_q.size() - 1;
      end
      default: begin
        // huge file size so the data never completes
        name_sz = $urandom_range(1, 20);
        put_header(name_sz, $urandom_range(0, 1) ? 32'hffffffff : $urandom, FLAW_NONE, STYLE_RANDOM);
        put_name(name_sz, NAME_RANDOM, 1'b0);
        repeat (30) put_byte(8'($urandom_range(0, 255)));
      end
    endcase
    repeat (20) put_byte(8'($urandom_range(0, 255)));
    idx = $urandom_range(first_tail, archive_q.size() - 1);
    a = archive_q[idx];
    a.last = 1'b1;
    archive_q[idx] = a;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (archive_q.size() != 0 || in_tvalid) @(posedge clk);
    while (squashed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && squashed_q.size() == 0) begin
      $display("tb_cpio_newc_id_squash_filter: PASS");
    end else begin
      $display("tb_cpio_newc_id_squash_filter: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cpiosq_pkg.sv
hdl/cpiosq_in_reg.sv
hdl/cpiosq_core.sv
hdl/cpio_newc_id_squash_filter.sv
dv/tb_cpio_newc_id_squash_filter.sv
